FILE: src/skyline_rectangle_packer_top_defines.svh
// Assertion helpers for the packer top level.
`ifndef SKYLINE_RECTANGLE_PACKER_TOP_DEFINES_SVH
`define SKYLINE_RECTANGLE_PACKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SKP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SKP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/skp_pkg.sv
package skp_pkg;

    localparam int SKP_MAX_NODES = 64;
    localparam int MAX_DIM       = 4096;
    localparam int MIN_DIM       = 128;
    localparam int PAD           = 2;
    localparam int DIM_W         = 13;
    localparam int VAL_W         = 15;
    localparam int PROD_W        = 26;
    localparam int RES_W         = 9;
    localparam int NODE_W        = 3 * DIM_W;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
    } t_node;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ITER,
        S_HCHK,
        S_GROW,
        S_FIT_START,
        S_FW_DATA,
        S_FW_ACC,
        S_FIT_END,
        S_FIT_CMP,
        S_DECIDE,
        S_RB_NEXT,
        S_RB_DATA,
        S_DONE
    } t_state;

endpackage

FILE: src/skp_ram.sv
module skp_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/skyline_rectangle_packer_top.sv
// Skyline rectangle packer.
// Input channel (i_valid / o_stall): i_mode 0 places a rect_width x rect_height
// rectangle padded by 2, i_mode 1 clears the atlas from the configuration registers.
// Output channel (o_valid / i_stall): one word per input word with status, position
// (plus 1), grew flag and the atlas size after the item.
// Configuration: i_cfg_we with i_cfg_index (0 initial width, 1 initial height,
// 2 reserved rows); write only while idle.
// One item is in work at a time. A placement scans every start node and the nodes spanned
// from it, then rebuilds the list; a growth doubles the atlas size step by step, a width
// growth also rebuilds the list, and each height doubling repeats the scan. The scan and
// the rebuild read one node at a time through the node memory read port.
// The node list lives in two banked RAMs: the rebuild streams the active bank into
// the other with the new node inserted, trimmed and merged, then swaps banks.
// After reset the block builds the first node in S_INIT before o_stall drops.
// A finished word waits in the output register while the receiver stalls; the next
// input word is taken meanwhile, and its result waits until the register frees.
`include "skyline_rectangle_packer_top_defines.svh"

module skyline_rectangle_packer_top import skp_pkg::*; #(
    parameter int MAX_NODES = SKP_MAX_NODES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_mode,
    input  logic [DIM_W-1:0]     i_rect_width,
    input  logic [DIM_W-1:0]     i_rect_height,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_status,
    output logic [DIM_W-1:0]     o_pos_x,
    output logic [DIM_W-1:0]     o_pos_y,
    output logic                 o_grew,
    output logic [DIM_W-1:0]     o_atlas_width,
    output logic [DIM_W-1:0]     o_atlas_height,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_NODES > 1 ? MAX_NODES : 2);
    localparam int CW = $clog2(MAX_NODES + 1);

    t_state r_state, n_state;

    logic [DIM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [RES_W-1:0]  r_cfg_res;

    logic              r_bank, n_bank;
    logic [CW-1:0]     r_count, n_count;
    logic [DIM_W-1:0]  r_cur_w, n_cur_w, r_cur_h, n_cur_h;

    logic [VAL_W-1:0]  r_w, n_w, r_h, n_h;
    logic              r_grew, n_grew, r_is_clear, n_is_clear;
    logic              r_status, n_status;
    logic [DIM_W-1:0]  r_px, n_px, r_py, n_py;

    logic [VAL_W-1:0]  r_gn, n_gn;
    logic              r_grow_h, n_grow_h;

    logic [CW-1:0]     r_i, n_i, r_j, n_j;
    logic              r_first, n_first;
    logic [DIM_W-1:0]  r_y, n_y, r_x0, n_x0;
    logic [VAL_W-1:0]  r_rem, n_rem;
    logic [PROD_W-1:0] r_prod, n_prod, r_sum, n_sum;
    logic              r_found, n_found;
    logic [CW-1:0]     r_best, n_best;
    logic [DIM_W-1:0]  r_bx, n_bx, r_by, n_by;
    logic [VAL_W-1:0]  r_btop, n_btop;
    logic [PROD_W-1:0] r_bwaste, n_bwaste;

    logic [CW-1:0]     r_k, n_k, r_idx, n_idx, r_wcnt, n_wcnt;
    t_node             r_new, n_new;
    logic [DIM_W:0]    r_right, n_right;
    logic              r_new_done, n_new_done, r_trim, n_trim, r_place, n_place;
    t_node             r_acc, n_acc;
    logic              r_acc_v, n_acc_v;

    logic              r_out_v, n_out_v;
    logic              r_o_status, n_o_status, r_o_grew, n_o_grew;
    logic [DIM_W-1:0]  r_o_px, n_o_px, r_o_py, n_o_py, r_o_w, n_o_w, r_o_h, n_o_h;

    logic              wr_en, wr_bank;
    logic [AW-1:0]     wr_addr, rd_addr;
    t_node             wr_data;
    logic [NODE_W-1:0] ram0_q, ram1_q;
    t_node             rd_node;

    logic              in_acc;
    logic              f_x_over, f_h_over, f_fail;
    logic [DIM_W-1:0]  f_y, f_used;
    logic [VAL_W-1:0]  f_rem;
    logic              last_start, last_span;
    logic [VAL_W-1:0]  c_top;
    logic [PROD_W-1:0] c_waste;
    logic              c_better;
    logic [VAL_W-1:0]  g_target;
    logic              g_step, g_over;
    logic [DIM_W-1:0]  ini_w, ini_h, ini_h1;
    logic [RES_W:0]    ini_hmin;
    logic [DIM_W:0]    t_ov;
    logic              t_as_is, t_drop;
    t_node             cand;
    logic              cand_v, merge;
    logic              out_free;

    // ------------------------------------------------------------ memories
    skp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (wr_en && !wr_bank),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram0_q)
    );

    skp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (wr_en && wr_bank),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram1_q)
    );

    assign rd_node = r_bank ? t_node'(ram1_q) : t_node'(ram0_q);

    // ------------------------------------------------------------ shared terms
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_v || !i_stall;

    assign f_x_over = ({2'b0, rd_node.x} + r_w) > ({2'b0, r_cur_w} - VAL_W'(1));
    assign f_y      = (r_first || rd_node.y > r_y) ? rd_node.y : r_y;
    assign f_h_over = ({2'b0, f_y} + r_h) > ({2'b0, r_cur_h} - VAL_W'(1));
    assign f_fail   = (r_first && f_x_over) || f_h_over;
    assign f_used   = (r_rem < {2'b0, rd_node.w}) ? r_rem[DIM_W-1:0] : rd_node.w;
    assign f_rem    = r_rem - {2'b0, f_used};

    assign last_start = (r_i + CW'(1)) >= r_count;
    assign last_span  = (r_j + CW'(1)) >= r_count;

    assign c_top    = {2'b0, r_y} + r_h;
    assign c_waste  = r_prod - r_sum;
    assign c_better = !r_found || (c_top < r_btop)
                   || (c_top == r_btop && c_waste < r_bwaste)
                   || (c_top == r_btop && c_waste == r_bwaste && r_x0 < r_bx);

    assign g_target = (r_grow_h ? r_h : r_w) + VAL_W'(PAD);
    assign g_step   = (r_gn < g_target) && (r_gn <= VAL_W'(MAX_DIM));
    assign g_over   = r_gn > VAL_W'(MAX_DIM);

    assign ini_w    = (r_cfg_w < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM)
                    : (r_cfg_w > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_cfg_w;
    assign ini_hmin = {1'b0, r_cfg_res} + (RES_W+1)'(PAD);
    assign ini_h1   = (r_cfg_h < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) : r_cfg_h;
    assign ini_h    = (ini_h1 < DIM_W'(ini_hmin)) ? DIM_W'(ini_hmin)
                    : (ini_h1 > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : ini_h1;

    assign t_ov    = r_right - {1'b0, rd_node.x};
    assign t_as_is = !r_trim || ({1'b0, rd_node.x} >= r_right);
    assign t_drop  = !t_as_is && (t_ov >= {1'b0, rd_node.w});

    always_comb begin
        cand   = rd_node;
        cand_v = 1'b0;
        if (r_state == S_RB_NEXT) begin
            cand   = r_new;
            cand_v = !r_new_done && (r_k == r_idx);
        end else if (r_state == S_RB_DATA) begin
            cand_v = !t_drop;
            if (!t_as_is) begin
                cand.x = r_right[DIM_W-1:0];
                cand.w = rd_node.w - t_ov[DIM_W-1:0];
            end
        end
    end

    assign merge = r_acc_v && (r_acc.y == cand.y)
                && (({1'b0, r_acc.x} + {1'b0, r_acc.w}) == {1'b0, cand.x});

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:      n_state = r_is_clear ? S_DONE : S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    n_state = i_mode ? S_INIT : S_ITER;
                end
            end
            S_ITER:      n_state = (r_w > {2'b0, r_cur_w} - VAL_W'(PAD)) ? S_GROW : S_HCHK;
            S_HCHK:      n_state = (r_h > {2'b0, r_cur_h} - VAL_W'(PAD)) ? S_GROW : S_FIT_START;
            S_GROW: begin
                if (!g_step) begin
                    if (g_over || (!r_grow_h && r_count >= CW'(MAX_NODES))) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = r_grow_h ? S_FIT_START : S_RB_NEXT;
                    end
                end
            end
            S_FIT_START: n_state = S_FW_DATA;
            S_FW_DATA: begin
                if (!f_fail) begin
                    n_state = S_FW_ACC;
                end else begin
                    n_state = last_start ? S_DECIDE : S_FIT_START;
                end
            end
            S_FW_ACC: begin
                if (r_rem == '0) begin
                    n_state = S_FIT_END;
                end else if (last_span) begin
                    n_state = last_start ? S_DECIDE : S_FIT_START;
                end else begin
                    n_state = S_FW_DATA;
                end
            end
            S_FIT_END:   n_state = S_FIT_CMP;
            S_FIT_CMP:   n_state = last_start ? S_DECIDE : S_FIT_START;
            S_DECIDE: begin
                if (r_found) begin
                    n_state = (r_count >= CW'(MAX_NODES)) ? S_DONE : S_RB_NEXT;
                end else begin
                    n_state = r_cur_h[DIM_W-1] || ({r_cur_h, 1'b0} > (DIM_W+1)'(MAX_DIM))
                            ? S_DONE : S_ITER;
                end
            end
            S_RB_NEXT: begin
                if (!(!r_new_done && r_k == r_idx)) begin
                    if (r_k < r_count) begin
                        n_state = S_RB_DATA;
                    end else begin
                        n_state = r_place ? S_DONE : S_HCHK;
                    end
                end
            end
            S_RB_DATA:   n_state = S_RB_NEXT;
            S_DONE:      n_state = out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------ datapath
    always_comb begin
        n_bank = r_bank;   n_count = r_count; n_cur_w = r_cur_w; n_cur_h = r_cur_h;
        n_w = r_w;         n_h = r_h;         n_grew = r_grew;   n_is_clear = r_is_clear;
        n_status = r_status; n_px = r_px;     n_py = r_py;
        n_gn = r_gn;       n_grow_h = r_grow_h;
        n_i = r_i;         n_j = r_j;         n_first = r_first; n_y = r_y; n_x0 = r_x0;
        n_rem = r_rem;     n_prod = r_prod;   n_sum = r_sum;     n_found = r_found;
        n_best = r_best;   n_bx = r_bx;       n_by = r_by;
        n_btop = r_btop;   n_bwaste = r_bwaste;
        n_k = r_k;         n_idx = r_idx;     n_wcnt = r_wcnt;   n_new = r_new;
        n_right = r_right; n_new_done = r_new_done; n_trim = r_trim; n_place = r_place;
        n_acc = r_acc;     n_acc_v = r_acc_v;
        n_out_v = r_out_v; n_o_status = r_o_status; n_o_grew = r_o_grew;
        n_o_px = r_o_px;   n_o_py = r_o_py;   n_o_w = r_o_w;     n_o_h = r_o_h;
        wr_en   = 1'b0;
        wr_bank = !r_bank;
        wr_addr = r_wcnt[AW-1:0];
        wr_data = r_acc;
        rd_addr = r_i[AW-1:0];

        if (r_out_v && !i_stall) begin
            n_out_v = 1'b0;
        end

        if (cand_v) begin
            if (merge) begin
                n_acc.w = r_acc.w + cand.w;
            end else begin
                if (r_acc_v) begin
                    wr_en  = 1'b1;
                    n_wcnt = r_wcnt + CW'(1);
                end
                n_acc   = cand;
                n_acc_v = 1'b1;
            end
        end

        case (r_state)
            S_INIT: begin
                wr_en      = 1'b1;
                wr_bank    = r_bank;
                wr_addr    = '0;
                wr_data.x  = DIM_W'(1);
                wr_data.y  = DIM_W'(r_cfg_res);
                wr_data.w  = ini_w - DIM_W'(PAD);
                n_cur_w    = ini_w;
                n_cur_h    = ini_h;
                n_count    = CW'(1);
                n_grew     = (ini_w != r_cur_w) || (ini_h != r_cur_h);
                n_status   = 1'b0;
                n_px       = '0;
                n_py       = '0;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_is_clear = i_mode;
                    n_w        = {2'b0, i_rect_width} + VAL_W'(PAD);
                    n_h        = {2'b0, i_rect_height} + VAL_W'(PAD);
                    n_grew     = 1'b0;
                end
            end
            S_ITER: begin
                n_gn     = {2'b0, r_cur_w};
                n_grow_h = 1'b0;
            end
            S_HCHK: begin
                n_gn     = {2'b0, r_cur_h};
                n_grow_h = 1'b1;
                n_i      = '0;
                n_found  = 1'b0;
            end
            S_GROW: begin
                if (g_step) begin
                    n_gn = {r_gn[VAL_W-2:0], 1'b0};
                end else if (g_over || (!r_grow_h && r_count >= CW'(MAX_NODES))) begin
                    n_status = 1'b1;
                    n_px     = '0;
                    n_py     = '0;
                end else if (r_grow_h) begin
                    n_cur_h = r_gn[DIM_W-1:0];
                    n_grew  = 1'b1;
                    n_i     = '0;
                    n_found = 1'b0;
                end else begin
                    n_new.x    = r_cur_w - DIM_W'(1);
                    n_new.y    = DIM_W'(r_cfg_res);
                    n_new.w    = r_gn[DIM_W-1:0] - r_cur_w;
                    n_right    = {1'b0, r_cur_w} - (DIM_W+1)'(1)
                               + {1'b0, r_gn[DIM_W-1:0] - r_cur_w};
                    n_idx      = r_count;
                    n_place    = 1'b0;
                    n_k        = '0;
                    n_wcnt     = '0;
                    n_new_done = 1'b0;
                    n_trim     = 1'b0;
                    n_acc_v    = 1'b0;
                    n_cur_w    = r_gn[DIM_W-1:0];
                    n_grew     = 1'b1;
                end
            end
            S_FIT_START: begin
                rd_addr = r_i[AW-1:0];
                n_j     = r_i;
                n_first = 1'b1;
                n_rem   = r_w;
                n_sum   = '0;
            end
            S_FW_DATA: begin
                if (f_fail) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_y     = f_y;
                    n_first = 1'b0;
                    n_rem   = f_rem;
                    n_prod  = rd_node.y * f_used;
                    if (r_first) begin
                        n_x0 = rd_node.x;
                    end
                end
            end
            S_FW_ACC: begin
                n_sum   = r_sum + r_prod;
                rd_addr = AW'(r_j + CW'(1));
                n_j     = r_j + CW'(1);
                if (r_rem != '0 && last_span) begin
                    n_i = r_i + CW'(1);
                end
            end
            S_FIT_END: begin
                n_prod = r_y * r_w[DIM_W-1:0];
            end
            S_FIT_CMP: begin
                if (c_better) begin
                    n_found  = 1'b1;
                    n_best   = r_i;
                    n_bx     = r_x0;
                    n_by     = r_y;
                    n_btop   = c_top;
                    n_bwaste = c_waste;
                end
                n_i = r_i + CW'(1);
            end
            S_DECIDE: begin
                if (r_found) begin
                    if (r_count >= CW'(MAX_NODES)) begin
                        n_status = 1'b1;
                        n_px     = '0;
                        n_py     = '0;
                    end else begin
                        n_new.x    = r_bx;
                        n_new.y    = DIM_W'(r_btop);
                        n_new.w    = r_w[DIM_W-1:0];
                        n_right    = {1'b0, r_bx} + {1'b0, r_w[DIM_W-1:0]};
                        n_idx      = r_best;
                        n_place    = 1'b1;
                        n_k        = '0;
                        n_wcnt     = '0;
                        n_new_done = 1'b0;
                        n_trim     = 1'b0;
                        n_acc_v    = 1'b0;
                        n_status   = 1'b0;
                        n_px       = r_bx + DIM_W'(1);
                        n_py       = r_by + DIM_W'(1);
                    end
                end else if (r_cur_h[DIM_W-1] || ({r_cur_h, 1'b0} > (DIM_W+1)'(MAX_DIM))) begin
                    n_status = 1'b1;
                    n_px     = '0;
                    n_py     = '0;
                end else begin
                    n_cur_h = {r_cur_h[DIM_W-2:0], 1'b0};
                    n_grew  = 1'b1;
                end
            end
            S_RB_NEXT: begin
                rd_addr = r_k[AW-1:0];
                if (!r_new_done && r_k == r_idx) begin
                    n_new_done = 1'b1;
                    n_trim     = 1'b1;
                end else if (r_k >= r_count) begin
                    wr_en   = 1'b1;
                    n_count = r_wcnt + CW'(1);
                    n_bank  = !r_bank;
                end
            end
            S_RB_DATA: begin
                n_k = r_k + CW'(1);
                if (!t_as_is && !t_drop) begin
                    n_trim = 1'b0;
                end else if (r_trim && t_as_is) begin
                    n_trim = 1'b0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_o_status = r_status;
                    n_o_grew   = r_grew;
                    n_o_px     = r_px;
                    n_o_py     = r_py;
                    n_o_w      = r_cur_w;
                    n_o_h      = r_cur_h;
                end
            end
            default: begin
                n_out_v = r_out_v;
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_cfg_w    <= DIM_W'(512);
            r_cfg_h    <= DIM_W'(512);
            r_cfg_res  <= RES_W'(36);
            r_bank     <= 1'b0;
            r_count    <= CW'(1);
            r_cur_w    <= DIM_W'(512);
            r_cur_h    <= DIM_W'(512);
            r_is_clear <= 1'b0;
            r_out_v    <= 1'b0;
            r_acc_v    <= 1'b0;
            r_new_done <= 1'b0;
            r_trim     <= 1'b0;
            r_found    <= 1'b0;
            r_wcnt     <= '0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INIT_WIDTH:  r_cfg_w   <= i_cfg_data;
                    CFG_INIT_HEIGHT: r_cfg_h   <= i_cfg_data;
                    CFG_RESERVED:    r_cfg_res <= i_cfg_data[RES_W-1:0];
                    default:         r_cfg_w   <= r_cfg_w;
                endcase
            end
            r_bank     <= n_bank;
            r_count    <= n_count;
            r_cur_w    <= n_cur_w;
            r_cur_h    <= n_cur_h;
            r_is_clear <= n_is_clear;
            r_out_v    <= n_out_v;
            r_acc_v    <= n_acc_v;
            r_new_done <= n_new_done;
            r_trim     <= n_trim;
            r_found    <= n_found;
            r_wcnt     <= n_wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_h        <= n_h;
        r_grew     <= n_grew;
        r_status   <= n_status;
        r_px       <= n_px;
        r_py       <= n_py;
        r_gn       <= n_gn;
        r_grow_h   <= n_grow_h;
        r_i        <= n_i;
        r_j        <= n_j;
        r_first    <= n_first;
        r_y        <= n_y;
        r_x0       <= n_x0;
        r_rem      <= n_rem;
        r_prod     <= n_prod;
        r_sum      <= n_sum;
        r_best     <= n_best;
        r_bx       <= n_bx;
        r_by       <= n_by;
        r_btop     <= n_btop;
        r_bwaste   <= n_bwaste;
        r_k        <= n_k;
        r_idx      <= n_idx;
        r_new      <= n_new;
        r_right    <= n_right;
        r_place    <= n_place;
        r_acc      <= n_acc;
        r_o_status <= n_o_status;
        r_o_grew   <= n_o_grew;
        r_o_px     <= n_o_px;
        r_o_py     <= n_o_py;
        r_o_w      <= n_o_w;
        r_o_h      <= n_o_h;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_v;
    assign o_status       = r_o_status;
    assign o_pos_x        = r_o_px;
    assign o_pos_y        = r_o_py;
    assign o_grew         = r_o_grew;
    assign o_atlas_width  = r_o_w;
    assign o_atlas_height = r_o_h;

    // ------------------------------------------------------------ assertions
    `SKP_ASSERT_SAME(a_count_range, i_clk, i_rst_n, r_state == S_IDLE, r_count != '0 && r_count <= CW'(MAX_NODES), "node count out of range")
    `SKP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, r_state != S_IDLE, "accepted word left block idle")
    `SKP_ASSERT_SAME(a_out_from_done, i_clk, i_rst_n, $rose(o_valid), $past(r_state == S_DONE), "result word without finished item")
    `SKP_ASSERT_SAME(a_rebuild_room, i_clk, i_rst_n, r_state == S_RB_NEXT, r_wcnt < CW'(MAX_NODES), "rebuild overran node store")

endmodule
